[design/ffba_pkg.sv]
// shared types and constants for the first-fit block allocator
package ffba_pkg;

  localparam int unsigned DATA_W = 16;
  localparam logic [DATA_W-1:0] HEAP_RESET = 16'd20480;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_ZERO  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_FIT     = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_ZERO_SIZE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT  = 3'd0,
    S_IDLE  = 3'd1,
    S_SCAN  = 3'd2,
    S_SPLIT = 3'd3,
    S_DONE  = 3'd4
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [DATA_W-1:0] key;
  } job_t;

  typedef struct packed {
    logic              is_free;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] offset;
  } entry_t;

endpackage

[design/ffba_front.sv]
// request front end: accepts beats, classifies them and queues jobs for the engine
module ffba_front
  import ffba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // request_bytes [15:0], free_address [31:16]
  input  logic              in_tuser,   // req_type
  output logic              job_valid,
  output job_t              job,
  input  logic              job_pop
);

  job_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  job_t       cls;

  // classify: zero-size allocates never need the table
  always_comb begin
    if (in_tuser) begin
      cls.op  = OP_FREE;
      cls.key = in_tdata[31:16];
    end else if (in_tdata[15:0] == '0) begin
      cls.op  = OP_ZERO;
      cls.key = in_tdata[15:0];
    end else begin
      cls.op  = OP_ALLOC;
      cls.key = in_tdata[15:0];
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = job_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, job_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

[design/ffba_back.sv]
// allocation engine: descriptor table memory, in-order scan, update and result register
module ffba_back
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DATA_W-1:0] cfg_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output status_t           out_tuser
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  entry_t            mem [MAX_ENTRIES];
  entry_t            rd_q_r;
  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              chk_v_r;
  logic [IW-1:0]     chk_idx_r;
  logic [DATA_W-1:0] res_addr_r, res_addr_nxt;
  status_t           res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_st_r;

  logic              issue, hit, miss, exact, full, out_free, cfg_take;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;

  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_take  = cfg_valid && cfg_ready;
  assign job_pop   = (state_r == S_IDLE) && job_valid && !cfg_valid;
  assign out_free  = !out_valid_r || out_tready;

  // one table read per cycle; the compare sees the registered read in the next cycle
  assign hit   = (state_r == S_SCAN) && chk_v_r &&
                 ((op_r == OP_ALLOC) ? (rd_q_r.is_free && rd_q_r.size >= key_r)
                                     : (rd_q_r.offset == key_r));
  assign issue = (state_r == S_SCAN) && !hit && (idx_r < count_r);
  assign miss  = (state_r == S_SCAN) && !chk_v_r && (idx_r >= count_r);
  assign exact = (rd_q_r.size == key_r);
  assign full  = (count_r == CW'(MAX_ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  state_nxt = S_IDLE;
      S_IDLE: begin
        if (job_pop) begin
          state_nxt = (job.op == OP_ZERO) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (op_r == OP_ALLOC && !exact && !full) ? S_SPLIT : S_DONE;
        end else if (miss) begin
          state_nxt = S_DONE;
        end
      end
      S_SPLIT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // datapath and table writes
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    idx_nxt       = issue ? idx_r + CW'(1) : idx_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en         = 1'b0;
    wr_addr       = chk_idx_r;
    wr_data       = rd_q_r;
    unique case (state_r)
      S_INIT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = '{is_free: 1'b1, size: HEAP_RESET, offset: '0};
        count_nxt = CW'(1);
      end
      S_IDLE: begin
        if (cfg_take) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = '{is_free: 1'b1, size: cfg_data, offset: '0};
          count_nxt = CW'(1);
        end else if (job_pop) begin
          op_nxt       = job.op;
          key_nxt      = job.key;
          idx_nxt      = '0;
          res_addr_nxt = '0;
          res_st_nxt   = ST_ZERO_SIZE;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_st_nxt = ST_OK;
          if (op_r == OP_FREE) begin
            wr_en           = 1'b1;
            wr_data.is_free = 1'b1;
          end else if (exact || !full) begin
            wr_en           = 1'b1;
            wr_data.is_free = 1'b0;
            wr_data.size    = key_r;
            res_addr_nxt    = rd_q_r.offset;
          end else begin
            res_st_nxt = ST_TABLE_FULL;
          end
        end else if (miss) begin
          res_st_nxt = (op_r == OP_FREE) ? ST_NOT_FOUND : ST_NO_FIT;
        end
      end
      S_SPLIT: begin
        // remainder goes to a new entry at the end of the table
        wr_en     = 1'b1;
        wr_addr   = count_r[IW-1:0];
        wr_data   = '{is_free: 1'b1, size: rd_q_r.size - key_r,
                      offset: rd_q_r.offset + key_r};
        count_nxt = count_r + CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CW'(1);
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_v_r     <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    chk_idx_r  <= idx_r[IW-1:0];
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    if (state_r == S_DONE && out_free) begin
      out_data_r <= res_addr_r;
      out_st_r   <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q_r <= mem[idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

endmodule

[design/first_fit_block_allocator_top.sv]
// first-fit block allocator: request queue in front of a table scan engine
// a request scans the table in order from entry 0 to its hit; a hit that splits a block
// adds an entry at the end, a miss scans every entry and a zero-size request skips the scan.
// throughput: one request at a time; the 2-deep request queue and the result register
// let both sides stall on their own
// reset: synchronous active-low rst_n, then the init state loads the one-block heap
module first_fit_block_allocator_top
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // request_bytes [15:0], free_address [31:16]
  input  logic        in_tuser,    // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // granted_address [15:0]
  output logic [2:0]  out_tuser,   // status [2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data     // heap_bytes
);

  logic    job_valid;
  job_t    job;
  logic    job_pop;
  status_t st;

  ffba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  ffba_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (st)
  );

  assign out_tuser = st;

endmodule
